### design/dec2fix_pkg.sv
// Shared types, character codes and scaling constants for the decimal text parser.
package dec2fix_pkg;

    // Number of fraction digits kept in the result.
    localparam int unsigned FRACTION_DIGITS = 4;

    // Powers of ten, evaluated at elaboration only.
    function automatic logic [63:0] pow10(int unsigned n);
        logic [63:0] r;
        r = 64'd1;
        for (int unsigned i = 0; i < n; i++)
        begin
            r = r * 64'd10;
        end
        return r;
    endfunction

    // Largest magnitude of the result and the fixed-point scale.
    localparam logic [63:0] MAG_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SCALE     = pow10(FRACTION_DIGITS);
    localparam logic [63:0] INT_CAP   = MAG_MAX / SCALE;

    // Widths of the accumulators. The integer part may grow by one on a rounding carry.
    localparam int INT_W = $clog2(INT_CAP + 64'd2);
    localparam int FRAC_W = $clog2(SCALE + 64'd1);
    localparam int CNT_W = $clog2(FRACTION_DIGITS + 2);
    localparam int PAD_N = 2 ** CNT_W;

    typedef logic [INT_W-1:0]  int_acc_t;
    typedef logic [FRAC_W-1:0] frac_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // Factor that left-aligns a fraction of the given digit count to the full scale.
    function automatic frac_t pad_factor(int unsigned cnt);
        frac_t f;
        if (cnt < FRACTION_DIGITS)
        begin
            f = FRAC_W'(pow10(FRACTION_DIGITS - cnt));
        end
        else
        begin
            f = FRAC_W'(1);
        end
        return f;
    endfunction

    // Character codes.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // A rounding digit at or above this value rounds the kept fraction up.
    localparam logic [3:0] ROUND_DIGIT = 4'd5;

    // Input word: one text byte.
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } in_word_t;

    // Result word: one parsed number.
    typedef struct packed {
        logic               valid_res;
        logic signed [63:0] value;
        logic               overflow;
    } out_word_t;

endpackage

### design/decimal_text_to_fixed_point_top.sv
// Streaming decimal text to signed fixed-point (scale 10^FRACTION_DIGITS) converter.
//
// Accepts one text byte per cycle on the char channel while char_stall is low and,
// for the byte flagged last_char, delivers one result word on the result channel
// through four registers (parse capture, fraction alignment and rounding, scaling
// and saturation, sign). Throughput is one byte per cycle while unstalled, set by
// the per-byte parser update, whose longest path is the multiply-by-ten-and-add of
// the integer accumulator followed by its compare against the saturation limit.
// Results travel through a four-deep register pipeline, so bytes keep flowing while
// finished results wait on result_stall; once all four stages hold a result,
// char_stall rises for every byte until the output side takes a word.
// Leading blanks are skipped, an optional sign and decimal digits with a point or
// comma are parsed, the first digit beyond the kept fraction rounds half up, and
// magnitudes above 2^63-1 set overflow and clamp to at most 2^63-1. Text with no
// digit, point or comma after blanks and sign gives valid_res low and value zero.
module decimal_text_to_fixed_point_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  char_valid,
    output logic                  char_stall,
    input  dec2fix_pkg::in_word_t char_word,
    output logic                  result_valid,
    input  logic                  result_stall,
    output dec2fix_pkg::out_word_t result_word
);
    import dec2fix_pkg::*;

    // Parser phases.
    localparam logic [2:0] PH_SKIP     = 3'd0;
    localparam logic [2:0] PH_SIGN     = 3'd1;
    localparam logic [2:0] PH_INT      = 3'd2;
    localparam logic [2:0] PH_FRAC     = 3'd3;
    localparam logic [2:0] PH_DONE_OK  = 3'd4;
    localparam logic [2:0] PH_DONE_BAD = 3'd5;

    localparam logic [INT_W+3:0] INT_CAP_X = (INT_W + 4)'(INT_CAP);
    localparam cnt_t             CNT_KEEP  = CNT_W'(FRACTION_DIGITS);
    localparam frac_t            SCALE_F   = FRAC_W'(SCALE);

    // Parser state.
    logic [2:0] phase_reg, phase_next;
    logic       neg_reg, neg_next;
    int_acc_t   acc_reg, acc_next;
    frac_t      frac_reg, frac_next;
    cnt_t       cnt_reg, cnt_next;
    logic       round_reg, round_next;
    logic       ovf_reg, ovf_next;

    // Stage 1: snapshot of the finished parse.
    logic       s1_valid_reg;
    logic       s1_ok_reg;
    logic       s1_neg_reg;
    int_acc_t   s1_acc_reg;
    frac_t      s1_frac_reg;
    cnt_t       s1_cnt_reg;
    logic       s1_round_reg;
    logic       s1_ovf_reg;

    // Stage 2: aligned and rounded parts.
    logic       s2_valid_reg;
    logic       s2_ok_reg;
    logic       s2_neg_reg;
    int_acc_t   s2_int_reg;
    frac_t      s2_frac_reg;
    logic       s2_ovf_reg;

    // Stage 3: saturated magnitude.
    logic        s3_valid_reg;
    logic        s3_ok_reg;
    logic        s3_neg_reg;
    logic [62:0] s3_mag_reg;
    logic        s3_ovf_reg;

    // Output register.
    logic      result_valid_reg;
    out_word_t result_word_reg;

    // Handshake and pipeline flow.
    logic char_fire;
    logic out_ready, s3_ready, s2_ready, s1_ready;

    assign out_ready  = !result_valid_reg || !result_stall;
    assign s3_ready   = !s3_valid_reg || out_ready;
    assign s2_ready   = !s2_valid_reg || s3_ready;
    assign s1_ready   = !s1_valid_reg || s2_ready;
    assign char_stall = !s1_ready;
    assign char_fire  = char_valid && !char_stall;

    // Byte classification.
    logic [7:0] ch;
    logic       is_blank, is_sign, is_digit, is_point;
    logic [3:0] digit;

    assign ch       = char_word.char_code;
    assign is_blank = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF) ||
                      (ch == CH_CR) || (ch == CH_FF);
    assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_point = (ch == CH_DOT) || (ch == CH_COMMA);
    assign digit    = ch[3:0];

    // Integer digit append with saturation at the largest integer part that fits.
    logic [INT_W+3:0] int_prod;
    logic             int_over;
    int_acc_t         int_add;

    assign int_prod = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} +
                      (INT_W + 4)'(digit);
    assign int_over = int_prod > INT_CAP_X;
    assign int_add  = int_over ? INT_W'(INT_CAP) : int_prod[INT_W-1:0];

    // Fraction digit append; only taken while fewer than the kept digits are in.
    logic [FRAC_W+3:0] frac_prod;

    assign frac_prod = {1'b0, frac_reg, 3'b000} + {3'b000, frac_reg, 1'b0} +
                       (FRAC_W + 4)'(digit);

    // Next parser state for the byte on the input.
    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        frac_next  = frac_reg;
        cnt_next   = cnt_reg;
        round_next = round_reg;
        ovf_next   = ovf_reg;
        unique case (phase_reg)
            PH_SKIP, PH_SIGN:
            begin
                priority if (phase_reg == PH_SKIP && is_blank)
                begin
                    phase_next = PH_SKIP;
                end
                else if (phase_reg == PH_SKIP && is_sign)
                begin
                    neg_next   = (ch == CH_MINUS);
                    phase_next = PH_SIGN;
                end
                else if (is_digit)
                begin
                    acc_next   = int_add;
                    ovf_next   = ovf_reg || int_over;
                    phase_next = PH_INT;
                end
                else if (is_point)
                begin
                    phase_next = PH_FRAC;
                end
                else
                begin
                    phase_next = PH_DONE_BAD;
                end
            end
            PH_INT:
            begin
                priority if (is_digit)
                begin
                    acc_next = int_add;
                    ovf_next = ovf_reg || int_over;
                end
                else if (is_point)
                begin
                    phase_next = PH_FRAC;
                end
                else
                begin
                    phase_next = PH_DONE_OK;
                end
            end
            PH_FRAC:
            begin
                priority if (is_digit)
                begin
                    if (cnt_reg < CNT_KEEP)
                    begin
                        frac_next = frac_prod[FRAC_W-1:0];
                        cnt_next  = cnt_reg + CNT_W'(1);
                    end
                    else if (cnt_reg == CNT_KEEP)
                    begin
                        round_next = (digit >= ROUND_DIGIT);
                        cnt_next   = cnt_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    phase_next = PH_DONE_OK;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Parser state registers; the final byte of a text returns them to reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            frac_reg  <= '0;
            cnt_reg   <= '0;
            round_reg <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else if (char_fire)
        begin
            if (char_word.last_char)
            begin
                phase_reg <= PH_SKIP;
                neg_reg   <= 1'b0;
                acc_reg   <= '0;
                frac_reg  <= '0;
                cnt_reg   <= '0;
                round_reg <= 1'b0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                acc_reg   <= acc_next;
                frac_reg  <= frac_next;
                cnt_reg   <= cnt_next;
                round_reg <= round_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= char_fire && char_word.last_char;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_ready)
            begin
                result_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Stage 1 capture of the parse that ends with this byte.
    always_ff @(posedge clk)
    begin
        if (char_fire && char_word.last_char)
        begin
            s1_ok_reg    <= (phase_next == PH_INT) || (phase_next == PH_FRAC) ||
                            (phase_next == PH_DONE_OK);
            s1_neg_reg   <= neg_next;
            s1_acc_reg   <= acc_next;
            s1_frac_reg  <= frac_next;
            s1_cnt_reg   <= cnt_next;
            s1_round_reg <= round_next;
            s1_ovf_reg   <= ovf_next;
        end
    end

    // Alignment factors, one for each possible count of fraction digits.
    frac_t pad_tab [PAD_N];

    for (genvar g = 0; g < PAD_N; g++)
    begin : g_pad
        assign pad_tab[g] = pad_factor(g);
    end

    // Stage 2: align the short fraction, then apply rounding with carry.
    logic [2*FRAC_W-1:0] frac_wide;
    frac_t               frac_aligned;
    frac_t               frac_rounded;
    logic                frac_carry;
    frac_t               s2_frac_next;
    int_acc_t            s2_int_next;

    assign frac_wide    = s1_frac_reg * pad_tab[s1_cnt_reg];
    assign frac_aligned = frac_wide[FRAC_W-1:0];
    assign frac_rounded = frac_aligned + FRAC_W'(s1_round_reg);
    assign frac_carry   = frac_rounded >= SCALE_F;
    assign s2_frac_next = frac_carry ? frac_rounded - SCALE_F : frac_rounded;
    assign s2_int_next  = s1_acc_reg + INT_W'(frac_carry);

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_ok_reg   <= s1_ok_reg;
            s2_neg_reg  <= s1_neg_reg;
            s2_int_reg  <= s2_int_next;
            s2_frac_reg <= s2_frac_next;
            s2_ovf_reg  <= s1_ovf_reg;
        end
    end

    // Stage 3: scale to fixed point and saturate the magnitude.
    logic [63:0] mag_full;
    logic        mag_over;

    assign mag_full = 64'(s2_int_reg) * SCALE + 64'(s2_frac_reg);
    assign mag_over = mag_full[63];

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            s3_ok_reg  <= s2_ok_reg;
            s3_neg_reg <= s2_neg_reg;
            s3_mag_reg <= mag_over ? MAG_MAX[62:0] : mag_full[62:0];
            s3_ovf_reg <= s2_ovf_reg || mag_over;
        end
    end

    // Output stage: apply the sign; an invalid text reads as zero.
    logic [63:0] mag_ext;

    assign mag_ext = {1'b0, s3_mag_reg};

    always_ff @(posedge clk)
    begin
        if (out_ready && s3_valid_reg)
        begin
            result_word_reg.valid_res <= s3_ok_reg;
            result_word_reg.overflow  <= s3_ok_reg && s3_ovf_reg;
            if (!s3_ok_reg)
            begin
                result_word_reg.value <= '0;
            end
            else if (s3_neg_reg)
            begin
                result_word_reg.value <= -$signed(mag_ext);
            end
            else
            begin
                result_word_reg.value <= $signed(mag_ext);
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result_word  = result_word_reg;

    // An invalid text always yields a zero value with no overflow.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_word.valid_res |->
            (result_word.value == 64'sd0) && !result_word.overflow)
        else $error("invalid result carries a nonzero value or overflow");

    // Saturation keeps the value off the most negative code.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_word.value != 64'sh8000_0000_0000_0000)
        else $error("result value reached the most negative code");

    // The final byte of a text returns the parser to its start.
    assert property (@(posedge clk) disable iff (!rst_n)
        char_fire && char_word.last_char |=>
            (phase_reg == PH_SKIP) && (acc_reg == '0) && (cnt_reg == '0) && !ovf_reg)
        else $error("parser not cleared after the final byte");

    // The accumulators stay within their saturation limits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (acc_reg <= INT_W'(INT_CAP)) && (frac_reg < SCALE_F) &&
            (cnt_reg <= CNT_KEEP + CNT_W'(1)))
        else $error("parser accumulator out of range");

endmodule
